FILE: src/double_ended_priority_queue_top_defines.svh
// Assertion macros used by the queue's top module.
`ifndef DOUBLE_ENDED_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define DOUBLE_ENDED_PRIORITY_QUEUE_TOP_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off while i_rst_n is low
`define DEP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dep: same-cycle check failed");

// next-cycle implication
`define DEP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dep: next-cycle check failed");

`endif

FILE: src/dep_pkg.sv
package dep_pkg;

    localparam int DEF_CAPACITY = 64;
    localparam int KEY_W        = 32;
    localparam int KCNT_W       = 7;
    localparam int CMD_W        = 2;
    localparam int STATUS_W     = 2;

    localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEL_MAX = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DEL_MIN = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_INS_RD,
        S_INS_CMP,
        S_INS_PUT,
        S_DMIN_RD,
        S_DMIN_MV,
        S_FETCH_LO,
        S_FETCH_HI,
        S_FETCH_END,
        S_FINISH
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DECIDE,
        OP_INS_RD,
        OP_INS_CMP,
        OP_INS_PUT,
        OP_DMIN_RD,
        OP_DMIN_MV,
        OP_FETCH_LO,
        OP_FETCH_HI,
        OP_FETCH_END,
        OP_RESULT
    } t_dp_op;

    typedef struct packed {
        logic is_ins;
        logic is_dmin;
        logic empty;
        logic full;
        logic one;
        logic greater;
        logic pos_one;
        logic more;
        logic out_free;
    } t_dp_stat;

endpackage

FILE: src/double_ended_priority_queue_top.sv
// Double-ended priority queue of signed 32-bit keys, duplicates kept.
// Input channel (i_valid / o_ready): one command per item, i_command
//   insert, delete maximum or delete minimum, with i_key_value for inserts.
// Output channel (o_valid / i_ready): one result per item: largest and
//   smallest key, count (low 7 bits), empty flag and status.
// Keys sit in ascending order in a single RAM (one write, one registered
// read per cycle); a sequencer moves one key per cycle. An insert takes longer
// the more stored keys are greater than the new key; a delete minimum of more
// than one key takes longer the more keys are stored. Before the result is
// loaded, the fetch states read the lowest and highest entries back.
// One item is in work at a time; o_ready rises in the same cycle as o_valid,
// so no new item is taken until the last one's result is loaded. A result
// waits in the output register; if the receiver still stalls when the next
// result is ready, the sequencer holds it and input stays blocked.
// Reset (synchronous, active low) empties the queue and drops any result
// not yet taken. RAM contents are not cleared; only entries below the count
// are ever used, so no clearing pass is needed.
`include "double_ended_priority_queue_top_defines.svh"

module double_ended_priority_queue_top #(
    parameter int CAPACITY = dep_pkg::DEF_CAPACITY
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [dep_pkg::CMD_W-1:0]        i_command,
    input  logic signed [dep_pkg::KEY_W-1:0] i_key_value,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic signed [dep_pkg::KEY_W-1:0] o_max_key,
    output logic signed [dep_pkg::KEY_W-1:0] o_min_key,
    output logic [dep_pkg::KCNT_W-1:0]       o_key_count,
    output logic                             o_is_empty,
    output logic [dep_pkg::STATUS_W-1:0]     o_status
);

    dep_pkg::t_dp_op   w_op;
    dep_pkg::t_dp_stat w_stat;

    // sequencer
    dep_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_stat (w_stat),
        .o_op   (w_op)
    );

    // key store, count, pointers and result register
    dep_dpath #(
        .CAPACITY(CAPACITY)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (w_op),
        .o_stat     (w_stat),
        .i_command  (i_command),
        .i_key_value(i_key_value),
        .i_out_ready(i_ready),
        .o_out_valid(o_valid),
        .o_max_key  (o_max_key),
        .o_min_key  (o_min_key),
        .o_key_count(o_key_count),
        .o_is_empty (o_is_empty),
        .o_status   (o_status)
    );

    // an accepted item always keeps the sequencer busy for the next cycle
    `DEP_ASSERT_NEXT(a_busy_after_accept, i_valid && o_ready, !o_ready)
    // a delete on an empty store must leave it empty
    `DEP_ASSERT_NOW(a_empty_status, o_valid && (o_status == dep_pkg::ST_EMPTY), o_is_empty)
    // empty store reports zero keys
    `DEP_ASSERT_NOW(a_empty_zero, o_valid && o_is_empty, (o_max_key == 0) && (o_min_key == 0))
    // ordering of the two ends
    `DEP_ASSERT_NOW(a_order, o_valid && !o_is_empty, o_max_key >= o_min_key)

endmodule

FILE: src/dep_ram.sv
module dep_ram #(
    parameter int WIDTH = dep_pkg::KEY_W,
    parameter int DEPTH = dep_pkg::DEF_CAPACITY,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/dep_ctrl.sv
module dep_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  dep_pkg::t_dp_stat i_stat,
    output dep_pkg::t_dp_op   o_op
);

    dep_pkg::t_state r_state;
    dep_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dep_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            dep_pkg::S_IDLE: begin
                if (i_valid) n_state = dep_pkg::S_DECIDE;
            end
            dep_pkg::S_DECIDE: begin
                n_state = dep_pkg::S_FETCH_LO;
                if (i_stat.is_ins) begin
                    if (i_stat.full)       n_state = dep_pkg::S_FETCH_LO;
                    else if (i_stat.empty) n_state = dep_pkg::S_INS_PUT;
                    else                   n_state = dep_pkg::S_INS_RD;
                end else if (i_stat.is_dmin && !i_stat.empty && !i_stat.one) begin
                    n_state = dep_pkg::S_DMIN_RD;
                end
            end
            dep_pkg::S_INS_RD:  n_state = dep_pkg::S_INS_CMP;
            dep_pkg::S_INS_CMP: begin
                if (!i_stat.greater)     n_state = dep_pkg::S_FETCH_LO;
                else if (i_stat.pos_one) n_state = dep_pkg::S_INS_PUT;
            end
            dep_pkg::S_INS_PUT:   n_state = dep_pkg::S_FETCH_LO;
            dep_pkg::S_DMIN_RD:   n_state = dep_pkg::S_DMIN_MV;
            dep_pkg::S_DMIN_MV: begin
                if (!i_stat.more) n_state = dep_pkg::S_FETCH_LO;
            end
            dep_pkg::S_FETCH_LO:  n_state = dep_pkg::S_FETCH_HI;
            dep_pkg::S_FETCH_HI:  n_state = dep_pkg::S_FETCH_END;
            dep_pkg::S_FETCH_END: n_state = dep_pkg::S_FINISH;
            dep_pkg::S_FINISH: begin
                if (i_stat.out_free) n_state = dep_pkg::S_IDLE;
            end
            default: n_state = dep_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ready = 1'b0;
        o_op    = dep_pkg::OP_NONE;
        case (r_state)
            dep_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) o_op = dep_pkg::OP_LOAD;
            end
            dep_pkg::S_DECIDE:    o_op = dep_pkg::OP_DECIDE;
            dep_pkg::S_INS_RD:    o_op = dep_pkg::OP_INS_RD;
            dep_pkg::S_INS_CMP:   o_op = dep_pkg::OP_INS_CMP;
            dep_pkg::S_INS_PUT:   o_op = dep_pkg::OP_INS_PUT;
            dep_pkg::S_DMIN_RD:   o_op = dep_pkg::OP_DMIN_RD;
            dep_pkg::S_DMIN_MV:   o_op = dep_pkg::OP_DMIN_MV;
            dep_pkg::S_FETCH_LO:  o_op = dep_pkg::OP_FETCH_LO;
            dep_pkg::S_FETCH_HI:  o_op = dep_pkg::OP_FETCH_HI;
            dep_pkg::S_FETCH_END: o_op = dep_pkg::OP_FETCH_END;
            dep_pkg::S_FINISH: begin
                if (i_stat.out_free) o_op = dep_pkg::OP_RESULT;
            end
            default: o_op = dep_pkg::OP_NONE;
        endcase
    end

endmodule

FILE: src/dep_dpath.sv
module dep_dpath #(
    parameter int CAPACITY = dep_pkg::DEF_CAPACITY
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  dep_pkg::t_dp_op                     i_op,
    output dep_pkg::t_dp_stat                   o_stat,
    input  logic [dep_pkg::CMD_W-1:0]           i_command,
    input  logic signed [dep_pkg::KEY_W-1:0]    i_key_value,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic signed [dep_pkg::KEY_W-1:0]    o_max_key,
    output logic signed [dep_pkg::KEY_W-1:0]    o_min_key,
    output logic [dep_pkg::KCNT_W-1:0]          o_key_count,
    output logic                                o_is_empty,
    output logic [dep_pkg::STATUS_W-1:0]        o_status
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KW = dep_pkg::KCNT_W;
    localparam int DW = dep_pkg::KEY_W;

    logic [dep_pkg::CMD_W-1:0]    r_cmd;
    logic [DW-1:0]                r_key;
    logic [AW-1:0]                r_pos;
    logic [CW-1:0]                r_count;
    logic [dep_pkg::STATUS_W-1:0] r_status;
    logic [DW-1:0]                r_min;
    logic [DW-1:0]                r_max;
    logic                         r_out_valid;
    logic [DW-1:0]                r_out_max;
    logic [DW-1:0]                r_out_min;
    logic [KW-1:0]                r_out_count;
    logic                         r_out_empty;
    logic [dep_pkg::STATUS_W-1:0] r_out_status;

    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [DW-1:0] w_wdata;
    logic [AW-1:0] w_raddr;
    logic [DW-1:0] w_rdata;

    logic              w_empty;
    logic              w_full;
    logic              w_one;
    logic              w_greater;
    logic              w_more;
    logic              w_is_ins;
    logic              w_is_dmax;
    logic              w_is_dmin;

    assign w_is_ins  = (r_cmd == dep_pkg::CMD_INSERT);
    assign w_is_dmax = (r_cmd == dep_pkg::CMD_DEL_MAX);
    assign w_is_dmin = (r_cmd == dep_pkg::CMD_DEL_MIN);
    assign w_empty   = (r_count == '0);
    assign w_full    = (r_count >= CW'(CAPACITY));
    assign w_one     = (r_count == CW'(1));
    assign w_greater = ($signed(w_rdata) > $signed(r_key));
    assign w_more    = ((CW'(r_pos) + CW'(1)) < r_count);

    always_comb begin
        o_stat          = '0;
        o_stat.is_ins   = w_is_ins;
        o_stat.is_dmin  = w_is_dmin;
        o_stat.empty    = w_empty;
        o_stat.full     = w_full;
        o_stat.one      = w_one;
        o_stat.greater  = w_greater;
        o_stat.pos_one  = (r_pos == AW'(1));
        o_stat.more     = w_more;
        o_stat.out_free = !r_out_valid || i_out_ready;
    end

    // memory port steering
    always_comb begin
        w_we    = 1'b0;
        w_waddr = '0;
        w_wdata = r_key;
        w_raddr = '0;
        case (i_op)
            dep_pkg::OP_INS_RD: w_raddr = r_pos - AW'(1);
            dep_pkg::OP_INS_CMP: begin
                w_we    = 1'b1;
                w_waddr = r_pos;
                w_wdata = w_greater ? w_rdata : r_key;
                w_raddr = r_pos - AW'(2);
            end
            dep_pkg::OP_INS_PUT: begin
                w_we    = 1'b1;
                w_waddr = r_pos;
            end
            dep_pkg::OP_DMIN_RD: w_raddr = r_pos;
            dep_pkg::OP_DMIN_MV: begin
                w_we    = 1'b1;
                w_waddr = r_pos - AW'(1);
                w_wdata = w_rdata;
                w_raddr = r_pos + AW'(1);
            end
            dep_pkg::OP_FETCH_HI: w_raddr = AW'(r_count - CW'(1));
            default: w_raddr = '0;
        endcase
    end

    dep_ram #(
        .WIDTH(DW),
        .DEPTH(CAPACITY)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (i_op)
                dep_pkg::OP_DECIDE: begin
                    if ((w_is_dmax && !w_empty) || (w_is_dmin && w_one)) begin
                        r_count <= r_count - CW'(1);
                    end
                end
                dep_pkg::OP_INS_CMP: begin
                    if (!w_greater) r_count <= r_count + CW'(1);
                end
                dep_pkg::OP_INS_PUT: r_count <= r_count + CW'(1);
                dep_pkg::OP_DMIN_MV: begin
                    if (!w_more) r_count <= r_count - CW'(1);
                end
                default: r_count <= r_count;
            endcase
            if (i_op == dep_pkg::OP_RESULT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        case (i_op)
            dep_pkg::OP_LOAD: begin
                r_cmd <= i_command;
                r_key <= i_key_value;
                r_pos <= (i_command == dep_pkg::CMD_INSERT) ? AW'(r_count) : AW'(1);
            end
            dep_pkg::OP_DECIDE: begin
                if (w_is_ins && w_full) begin
                    r_status <= dep_pkg::ST_FULL;
                end else if ((w_is_dmax || w_is_dmin) && w_empty) begin
                    r_status <= dep_pkg::ST_EMPTY;
                end else begin
                    r_status <= dep_pkg::ST_DONE;
                end
            end
            dep_pkg::OP_INS_CMP: begin
                if (w_greater) r_pos <= r_pos - AW'(1);
            end
            dep_pkg::OP_DMIN_MV: begin
                if (w_more) r_pos <= r_pos + AW'(1);
            end
            dep_pkg::OP_FETCH_HI:  r_min <= w_empty ? '0 : w_rdata;
            dep_pkg::OP_FETCH_END: r_max <= w_empty ? '0 : w_rdata;
            dep_pkg::OP_RESULT: begin
                r_out_max    <= r_max;
                r_out_min    <= r_min;
                // count reported modulo 128
                r_out_count  <= KW'(r_count);
                r_out_empty  <= w_empty;
                r_out_status <= r_status;
            end
            default: r_pos <= r_pos;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_max_key   = $signed(r_out_max);
    assign o_min_key   = $signed(r_out_min);
    assign o_key_count = r_out_count;
    assign o_is_empty  = r_out_empty;
    assign o_status    = r_out_status;

endmodule
